// ===== rtl/core/lmsf_pkg.sv =====
package lmsf_pkg;

    // Number of coefficient slots and delay line entries.
    localparam int MAX_TAPS = 32;

    // Address of one tap, and a count that can also hold MAX_TAPS itself.
    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);

    localparam int DATA_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int IDX_W      = 5;
    localparam int SHIFT_W    = 4;
    localparam int TAPS_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POST_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 2'd2;

    // Input beat kinds.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SCALE,
        ST_ERR,
        ST_MU,
        ST_ALPHA,
        ST_UPD,
        ST_FIN
    } state_t;

    // Control from the sequencer to the tap storage.
    typedef struct packed {
        logic                     shift_en;
        logic signed [DATA_W-1:0] shift_data;
        logic                     coef_we;
        logic [TAP_AW-1:0]        coef_waddr;
        logic signed [DATA_W-1:0] coef_wdata;
        logic [TAP_AW-1:0]        coef_raddr;
        logic [TAP_AW-1:0]        dl_raddr;
    } taps_ctl_t;

endpackage

// ===== rtl/core/lmsf_mul.sv =====
module lmsf_mul (
    input  logic                                     clk,
    input  logic signed [lmsf_pkg::DATA_W-1:0]       a,
    input  logic signed [lmsf_pkg::DATA_W-1:0]       b,
    output logic signed [lmsf_pkg::PROD_W-1:0]       product
);
    import lmsf_pkg::*;

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    // One signed 16 x 16 product per cycle, registered.
    assign p_next  = a * b;
    assign product = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

// ===== rtl/core/lmsf_taps.sv =====
module lmsf_taps (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lmsf_pkg::taps_ctl_t                  ctl,
    output logic signed [lmsf_pkg::DATA_W-1:0]   coef_rdata,
    output logic signed [lmsf_pkg::DATA_W-1:0]   dl_rdata
);
    import lmsf_pkg::*;

    logic signed [DATA_W-1:0] dl_reg   [MAX_TAPS];
    logic signed [DATA_W-1:0] coef_reg [MAX_TAPS];

    // Entry 0 of the delay line holds the newest sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (ctl.shift_en)
        begin
            for (int i = MAX_TAPS - 1; i > 0; i--)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
            dl_reg[0] <= ctl.shift_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (ctl.coef_we)
        begin
            coef_reg[ctl.coef_waddr] <= ctl.coef_wdata;
        end
    end

    assign coef_rdata = coef_reg[ctl.coef_raddr];
    assign dl_rdata   = dl_reg[ctl.dl_raddr];

endmodule

// ===== rtl/core/lms_adaptive_fir_q15_unit.sv =====
// Q15 LMS adaptive FIR filter. Each input beat either loads one coefficient
// (action 0, stays idle, no result) or processes one sample (action 1).
// A sample is shifted into the delay line, the active coefficients are
// multiplied against the window with coefficient 0 on the oldest sample, the
// sum is scaled by 15 minus post_shift and saturated to give filter_out, and
// error_out is reference_in minus filter_out. The coefficients are then
// adapted from the error and step_size. A single shared 16 x 16 multiplier
// visits every active tap twice, once for the dot product and once for the
// coefficient update, with the scaling, the error and the adapted step
// between. in_stall stays high while a sample is in progress. The result
// sits in an output register, so a new beat can be taken while the previous
// result still waits behind out_stall. Configuration writes are meant to
// land only while the block is idle.
module lms_adaptive_fir_q15_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_write,
    input  logic [lmsf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lmsf_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   action,
    input  logic [lmsf_pkg::IDX_W-1:0]             coef_index,
    input  logic signed [lmsf_pkg::DATA_W-1:0]     coef_value,
    input  logic signed [lmsf_pkg::DATA_W-1:0]     sample_in,
    input  logic signed [lmsf_pkg::DATA_W-1:0]     reference_in,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [lmsf_pkg::DATA_W-1:0]     filter_out,
    output logic signed [lmsf_pkg::DATA_W-1:0]     error_out
);
    import lmsf_pkg::*;

    // Configuration registers.
    logic signed [DATA_W-1:0]  step_reg;
    logic [SHIFT_W-1:0]        pshift_reg;
    logic [TAPS_W-1:0]         taps_reg;

    // Sequencer state.
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic                      pv_reg, pv_next;
    logic [TAP_AW-1:0]         pidx_reg, pidx_next;

    // Datapath registers.
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DATA_W-1:0]  ref_reg, ref_next;
    logic signed [DATA_W-1:0]  y_reg, y_next;
    logic signed [DATA_W-1:0]  e_reg, e_next;
    logic signed [DATA_W-1:0]  alpha_reg, alpha_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  filter_out_reg, filter_out_next;
    logic signed [DATA_W-1:0]  error_out_reg, error_out_next;

    // Shared multiplier and tap storage.
    logic signed [DATA_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  product;
    taps_ctl_t                 taps_ctl;
    logic signed [DATA_W-1:0]  coef_rdata, dl_rdata;

    // Helpers.
    logic [CNT_W-1:0]          n_taps;
    logic [SHIFT_W-1:0]        out_shift;
    logic signed [ACC_W-1:0]   acc_shifted;
    logic signed [PROD_W-1:0]  acc_low;
    logic signed [DATA_W+1:0]  coef_sum;
    logic signed [DATA_W:0]    err_wide;

    lmsf_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    lmsf_taps u_taps (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (taps_ctl),
        .coef_rdata (coef_rdata),
        .dl_rdata   (dl_rdata)
    );

    // Active tap count: zero acts as one, anything above the storage as full.
    always_comb
    begin
        if (taps_reg == '0)
        begin
            n_taps = CNT_W'(1);
        end
        else if (int'(taps_reg) > MAX_TAPS)
        begin
            n_taps = CNT_W'(MAX_TAPS);
        end
        else
        begin
            n_taps = CNT_W'(taps_reg);
        end
    end

    // Output scaling: arithmetic shift of the sum, low 32 bits kept as signed.
    assign out_shift   = SHIFT_W'(4'd15) - pshift_reg;
    assign acc_shifted = acc_reg >>> out_shift;
    assign acc_low     = acc_shifted[PROD_W-1:0];

    // Coefficient update: product shifted right 15 (floor) added to the tap.
    assign coef_sum = {{2{coef_rdata[DATA_W-1]}}, coef_rdata}
                    + {product[PROD_W-1], product[PROD_W-1:15]};

    assign err_wide = {ref_reg[DATA_W-1], ref_reg} - {y_reg[DATA_W-1], y_reg};

    // Multiplier operands: coefficient by sample for the dot product, error by
    // step size once, then alpha by sample for the update.
    always_comb
    begin
        mul_a = alpha_reg;
        mul_b = dl_rdata;
        if (state_reg == ST_MAC)
        begin
            mul_a = coef_rdata;
        end
        else if (state_reg == ST_MU)
        begin
            mul_a = e_reg;
            mul_b = step_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        acc_next        = acc_reg;
        ref_next        = ref_reg;
        y_next          = y_reg;
        e_next          = e_reg;
        alpha_next      = alpha_reg;
        filter_out_next = filter_out_reg;
        error_out_next  = error_out_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        taps_ctl            = '0;
        taps_ctl.shift_data = sample_in;
        taps_ctl.coef_wdata = coef_value;
        taps_ctl.coef_waddr = TAP_AW'(coef_index);
        taps_ctl.coef_raddr = TAP_AW'(k_reg);
        taps_ctl.dl_raddr   = TAP_AW'(n_taps - k_reg - CNT_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_LOAD)
                    begin
                        // Loads to slots beyond the storage are dropped.
                        taps_ctl.coef_we = (int'(coef_index) < MAX_TAPS);
                    end
                    else
                    begin
                        taps_ctl.shift_en = 1'b1;
                        ref_next          = reference_in;
                        acc_next          = '0;
                        k_next            = '0;
                        pv_next           = 1'b0;
                        state_next        = ST_MAC;
                    end
                end
            end

            ST_MAC:
            begin
                if (pv_reg)
                begin
                    acc_next = acc_reg
                             + {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};
                end
                if (k_reg < n_taps)
                begin
                    pv_next = 1'b1;
                    k_next  = k_reg + CNT_W'(1);
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = ST_SCALE;
                    end
                end
            end

            ST_SCALE:
            begin
                if (acc_low > 32'sd32767)
                begin
                    y_next = 16'sh7fff;
                end
                else if (acc_low < -32'sd32768)
                begin
                    y_next = 16'sh8000;
                end
                else
                begin
                    y_next = acc_low[DATA_W-1:0];
                end
                state_next = ST_ERR;
            end

            ST_ERR:
            begin
                e_next     = err_wide[DATA_W-1:0];
                state_next = ST_MU;
            end

            ST_MU:
            begin
                state_next = ST_ALPHA;
            end

            ST_ALPHA:
            begin
                // Shift right 15 and wrap to 16 bits.
                alpha_next = product[DATA_W+14:15];
                k_next     = '0;
                pv_next    = 1'b0;
                state_next = ST_UPD;
            end

            ST_UPD:
            begin
                taps_ctl.coef_raddr = pidx_reg;
                taps_ctl.coef_waddr = pidx_reg;
                if (pv_reg)
                begin
                    taps_ctl.coef_we = 1'b1;
                    if (coef_sum > 18'sd32767)
                    begin
                        taps_ctl.coef_wdata = 16'sh7fff;
                    end
                    else if (coef_sum < -18'sd32768)
                    begin
                        taps_ctl.coef_wdata = 16'sh8000;
                    end
                    else
                    begin
                        taps_ctl.coef_wdata = coef_sum[DATA_W-1:0];
                    end
                end
                if (k_reg < n_taps)
                begin
                    pv_next   = 1'b1;
                    pidx_next = TAP_AW'(k_reg);
                    k_next    = k_reg + CNT_W'(1);
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    filter_out_next = y_reg;
                    error_out_next  = e_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 16'sd512;
            pshift_reg <= '0;
            taps_reg   <= TAPS_W'(32);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:   step_reg   <= cfg_data;
                REG_POST_SHIFT:  pshift_reg <= cfg_data[SHIFT_W-1:0];
                REG_TAPS_IN_USE: taps_reg   <= cfg_data[TAPS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        acc_reg        <= acc_next;
        ref_reg        <= ref_next;
        y_reg          <= y_next;
        e_reg          <= e_next;
        alpha_reg      <= alpha_next;
        filter_out_reg <= filter_out_next;
        error_out_reg  <= error_out_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign filter_out = filter_out_reg;
    assign error_out  = error_out_reg;

endmodule

// ===== rtl/core/lmsf_checker.sv =====
module lmsf_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 action,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [lmsf_pkg::DATA_W-1:0]   filter_out,
    input logic signed [lmsf_pkg::DATA_W-1:0]   error_out
);
    import lmsf_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filter_out) && $stable(error_out))
        else $error("stalled result beat changed");

    // A sample beat keeps the block busy in the following cycle.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_SAMPLE |=> in_stall)
        else $error("block free right after a sample beat");

    // A coefficient load leaves the block free in the following cycle.
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_LOAD |=> !in_stall)
        else $error("block busy after a coefficient load");

    // A new result appears only at the end of sample processing.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised while idle");

endmodule

bind lms_adaptive_fir_q15_unit lmsf_checker u_lmsf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .filter_out (filter_out),
    .error_out  (error_out)
);
